/* design/cpsm_pkg.sv */
`default_nettype none
package cpsm_pkg;

  localparam int unsigned CpsmByteW     = 8;
  localparam int unsigned CpsmKeyW      = 7;
  localparam int unsigned CpsmQueueDepth = 4;

  localparam logic [CpsmKeyW-1:0]  CpsmKeyMax  = 7'd93;
  localparam logic [CpsmByteW-1:0] CpsmRangeLo = 8'd33;
  localparam logic [CpsmByteW-1:0] CpsmRangeHi = 8'd126;
  localparam logic [CpsmByteW-1:0] CpsmRangeN  = 8'd94;
  localparam logic [CpsmByteW-1:0] CpsmColon   = 8'h3A;

  // number of letters in the kept prefix
  localparam logic [1:0] CpsmPrefixLen = 2'd3;

  // one queued request: what the back end has to emit for one input byte
  typedef struct packed {
    logic                keep_set;  // emit "set" unchanged first
    logic [1:0]          enc_cnt;   // held prefix letters to emit rotated
    logic                has_byte;  // emit the input byte rotated last
    logic [CpsmByteW-1:0] data;
    logic                last;
  } cpsm_desc_t;

  function automatic logic [CpsmByteW-1:0] prefix_char(input logic [1:0] idx);
    logic [CpsmByteW-1:0] c;
    unique case (idx)
      2'd0:    c = 8'h73;  // s
      2'd1:    c = 8'h65;  // e
      2'd2:    c = 8'h74;  // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [CpsmByteW-1:0] rotate_byte(
    input logic [CpsmByteW-1:0] b,
    input logic [CpsmKeyW-1:0]  key
  );
    logic [CpsmByteW:0]   s;
    logic [CpsmByteW-1:0] r;
    s = {1'b0, b} + {2'b00, key};
    if (s > {1'b0, CpsmRangeHi}) begin
      s = s - {1'b0, CpsmRangeN};
    end
    if (b == CpsmColon || b < CpsmRangeLo || b > CpsmRangeHi) begin
      r = b;
    end else begin
      r = s[CpsmByteW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/cpsm_front.sv */
`default_nettype none
module cpsm_front (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [cpsm_pkg::CpsmByteW-1:0]  in_byte_i,
  input  wire                             in_last_i,
  input  wire                             q_full_i,
  output logic                            push_o,
  output cpsm_pkg::cpsm_desc_t            push_desc_o
);
  import cpsm_pkg::*;

  logic [1:0] held_q, held_d;
  logic       checking_q, checking_d;
  logic       accept;
  logic       need_push;
  logic [1:0] eff_held;
  logic       keep;
  logic       match;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    keep     = checking_q && (held_q == CpsmPrefixLen);
    eff_held = keep ? 2'd0 : held_q;
    match    = (in_byte_i == prefix_char(eff_held)) && !in_last_i;

    held_d      = held_q;
    checking_d  = checking_q;
    need_push   = 1'b1;
    push_desc_o = '{keep_set: 1'b0, enc_cnt: 2'd0, has_byte: 1'b1,
                    data: in_byte_i, last: in_last_i};

    if (checking_q) begin
      push_desc_o.keep_set = keep;
      if (match) begin
        // still forming the prefix: hold the letter
        held_d               = eff_held + 2'd1;
        push_desc_o.has_byte = 1'b0;
        need_push            = keep;
      end else begin
        // mismatch or end of name: flush held letters rotated
        push_desc_o.enc_cnt = eff_held;
        held_d              = 2'd0;
        checking_d          = 1'b0;
      end
    end

    if (in_last_i) begin
      held_d     = 2'd0;
      checking_d = 1'b1;
    end
  end

  assign push_o = accept && need_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= 2'd0;
      checking_q <= 1'b1;
    end else if (accept) begin
      held_q     <= held_d;
      checking_q <= checking_d;
    end
  end

  // every queued request must produce at least one byte
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (push_desc_o.keep_set || push_desc_o.has_byte))
    else $error("empty request pushed");

endmodule
`default_nettype wire

/* design/cpsm_queue.sv */
`default_nettype none
module cpsm_queue #(
  parameter int unsigned Depth = cpsm_pkg::CpsmQueueDepth
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  cpsm_pkg::cpsm_desc_t  push_desc_i,
  output logic                  full_o,
  input  wire                   pop_i,
  output logic                  empty_o,
  output cpsm_pkg::cpsm_desc_t  head_o
);
  import cpsm_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  cpsm_desc_t    mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] count_q;

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("queue count out of range");

endmodule
`default_nettype wire

/* design/cpsm_back.sv */
`default_nettype none
module cpsm_back (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [cpsm_pkg::CpsmKeyW-1:0]   cfg_shift_key_i,
  input  wire                             q_empty_i,
  input  cpsm_pkg::cpsm_desc_t            head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [cpsm_pkg::CpsmByteW-1:0]  out_byte_o,
  output logic                            out_last_o
);
  import cpsm_pkg::*;

  logic [CpsmKeyW-1:0]  key_q;
  logic [1:0]           idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;
  logic [CpsmByteW-1:0] out_byte_q, out_byte_d;
  logic                 out_last_q, out_last_d;
  logic                 load;
  logic [2:0]           base, total, idx3, k3;
  logic                 is_end;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i) begin
      key_q <= (cfg_shift_key_i > CpsmKeyMax) ? CpsmKeyMax : cfg_shift_key_i;
    end
  end

  // slot order: kept "set", rotated held letters, rotated input byte
  always_comb begin
    base   = head_i.keep_set ? {1'b0, CpsmPrefixLen} : 3'd0;
    total  = base + {1'b0, head_i.enc_cnt} + {2'b00, head_i.has_byte};
    idx3   = {1'b0, idx_q};
    k3     = idx3 - base;
    is_end = (idx3 == total - 3'd1);

    if (head_i.keep_set && idx3 < {1'b0, CpsmPrefixLen}) begin
      out_byte_d = prefix_char(idx_q);
    end else if (k3 < {1'b0, head_i.enc_cnt}) begin
      out_byte_d = rotate_byte(prefix_char(k3[1:0]), key_q);
    end else begin
      out_byte_d = rotate_byte(head_i.data, key_q);
    end
    out_last_d = head_i.last && is_end;
  end

  assign load        = !out_valid_q || !out_stall_i;
  assign out_valid_d = !q_empty_i;
  assign pop_o       = load && !q_empty_i && is_end;

  always_comb begin
    idx_d = idx_q;
    if (load && !q_empty_i) begin
      idx_d = is_end ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= out_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !q_empty_i) begin
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // slot index only advances inside a request
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty_i |-> (idx_q == 2'd0))
    else $error("slot index set with empty queue");

endmodule
`default_nettype wire

/* design/caesar_printable_stream_mangler.sv */
`default_nettype none
// Caesar mangler for printable names, one byte per request. Bytes 33..126
// other than ':' are rotated by shift_key within that 94-character range;
// everything else passes unchanged. A name (or its remainder after a kept
// "set") that begins with "set" and has a further byte keeps "set" as is.
// The front end takes one input byte per cycle whenever the request queue
// has room and turns it into a queued request of 0..4 output bytes (held
// prefix letters produce nothing). The back end drains the queue at one
// output byte per cycle while out_stall_i is low; a request passes through
// the queue, then the registered output stage. An input that releases a
// held prefix yields 2..4 output bytes; since held letters emit nothing,
// sustained throughput stays at one input per cycle for ordinary names
// while the output is not stalled. shift_key writes above 93 saturate to
// 93. The key port is always ready and queued bytes are rotated with the
// current key, so write it only while no name is in flight.
module caesar_printable_stream_mangler #(
  parameter int unsigned QUEUE_DEPTH = cpsm_pkg::CpsmQueueDepth
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // key register write
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [cpsm_pkg::CpsmKeyW-1:0]   cfg_shift_key_i,
  // input bytes
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [cpsm_pkg::CpsmByteW-1:0]  in_byte_i,
  input  wire                             in_last_i,
  // output bytes
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [cpsm_pkg::CpsmByteW-1:0]  out_byte_o,
  output logic                            out_last_o
);
  import cpsm_pkg::*;

  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  cpsm_desc_t push_desc;
  cpsm_desc_t head;

  // front end: prefix tracking, builds one request per input byte
  cpsm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  // decouples the two ends
  cpsm_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  // back end: key register, rotation, one byte per cycle out while not stalled
  cpsm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_shift_key_i (cfg_shift_key_i),
    .q_empty_i       (q_empty),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .out_last_o      (out_last_o)
  );

endmodule
`default_nettype wire

/* verif/caesar_printable_stream_mangler_test.sv */
`timescale 1ns / 1ps

module caesar_printable_stream_mangler_test;
  import cpsm_pkg::*;

  localparam int HoldLen   = 120;   // long receiver hold, in cycles
  localparam int IdleLimit = 1000;  // watchdog: cycles with no handshake at all
  localparam int SettleCyc = 8;     // pipeline settle time after the last byte

  // prefix kept unchanged when followed by another byte
  localparam logic [23:0] SetWord = "set";

  typedef struct packed {
    logic [CpsmByteW-1:0] data;
    logic                 last;
  } out_req_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CpsmKeyW-1:0]  cfg_shift_key_i = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [CpsmByteW-1:0] in_byte_i       = '0;
  logic                 in_last_i       = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [CpsmByteW-1:0] out_byte_o;
  logic                 out_last_o;

  caesar_printable_stream_mangler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_shift_key_i(cfg_shift_key_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .in_last_i      (in_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Mangler model: own copy of key and prefix-scan state
  // ---------------------------------------------------------------------
  logic [CpsmKeyW-1:0] key_model = '0;
  logic [1:0]          held_n    = '0;    // s/e/t letters held back
  logic                scan_on   = 1'b1;  // still looking for "set"

  out_req_t pending_bytes[$];             // expected output bytes, oldest first
  logic [CpsmByteW-1:0] name_buf[$];      // name under construction

  int err_count     = 0;
  int bytes_checked = 0;
  int items_sent    = 0;
  int names_sent    = 0;
  int key_writes    = 0;

  // stimulus shaping
  bit quiet    = 1'b0;  // no idling on either side
  bit steady   = 1'b0;  // sender never pauses
  bit hold_req = 1'b0;  // receiver long hold requested
  int hold_cnt = 0;
  int stall_left = 0;
  logic hold_active;

  function automatic logic [CpsmByteW-1:0] set_letter(input int idx);
    return SetWord[8*(2-idx) +: 8];
  endfunction

  // rotate within 33..126, colon and everything outside untouched
  function automatic logic [CpsmByteW-1:0] mangle_char(input logic [CpsmByteW-1:0] c);
    logic [CpsmByteW:0] sum;
    if (c == CpsmColon || c < CpsmRangeLo || c > CpsmRangeHi) return c;
    sum = c + key_model;
    if (sum > CpsmRangeHi) sum = sum - CpsmRangeN;
    return sum[CpsmByteW-1:0];
  endfunction

  // expected bytes for one accepted input byte
  task automatic predict_mangle(input logic [CpsmByteW-1:0] b, input logic lst);
    out_req_t res[$];
    out_req_t r;
    r.last = 1'b0;
    if (!scan_on) begin
      r.data = mangle_char(b);
      res.push_back(r);
    end else begin
      // fourth byte after a full "set": keep "set" as is, scan again
      if (held_n == 2'd3) begin
        for (int i = 0; i < 3; i++) begin
          r.data = set_letter(i);
          res.push_back(r);
        end
        held_n = '0;
      end
      if (b == set_letter(held_n) && !lst) begin
        held_n = held_n + 2'd1;
      end else begin
        // mismatch or name end: held letters go out rotated
        for (int i = 0; i < held_n; i++) begin
          r.data = mangle_char(set_letter(i));
          res.push_back(r);
        end
        r.data = mangle_char(b);
        res.push_back(r);
        held_n  = '0;
        scan_on = 1'b0;
      end
    end
    if (lst) begin
      if (res.size() > 0) res[res.size()-1].last = 1'b1;
      held_n  = '0;
      scan_on = 1'b1;
    end
    foreach (res[i]) pending_bytes.push_back(res[i]);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: random stall bursts, plus a long hold when asked
  // ---------------------------------------------------------------------
  assign hold_active = hold_req && (hold_cnt < HoldLen);

  // hold length is counted here, independent of the sender
  always @(posedge clk_i) begin
    if (!hold_req) hold_cnt <= 0;
    else if (hold_cnt < HoldLen) hold_cnt <= hold_cnt + 1;
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) stall_left = stall_left - 1;
    else if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 17);
    out_stall_i <= hold_active || (stall_left > 0);
  end

  // output checker: compare each accepted byte with the oldest expectation
  always @(posedge clk_i) begin : check_out
    out_req_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %h last %b", out_byte_o, out_last_o));
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (out_byte_o !== want.data)
          report_mismatch($sformatf("byte %h, want %h", out_byte_o, want.data));
        if (out_last_o !== want.last)
          report_mismatch($sformatf("last %b, want %b (byte %h)", out_last_o, want.last,
                                    want.data));
      end
    end
  end

  // watchdog: any handshake on any channel counts as progress
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("[%0t] watchdog: no progress for %0d cycles", $time, IdleLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------
  // Valid stays high from one request to the next unless a gap is taken;
  // every pause lowers valid first so no request is sent twice.
  task automatic send_byte(input logic [CpsmByteW-1:0] b, input logic lst);
    int gap;
    if (!quiet && !steady && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= lst;
    do @(posedge clk_i); while (in_stall_o);
    predict_mangle(b, lst);
    items_sent++;
  endtask

  task automatic send_name();
    foreach (name_buf[i]) send_byte(name_buf[i], i == name_buf.size() - 1);
    names_sent++;
    name_buf.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
  endtask

  // sender stops until every expected byte has come out, then settles
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // only called while idle, between names
  task automatic write_shift_key(input logic [CpsmKeyW-1:0] v);
    cfg_valid_i     <= 1'b1;
    cfg_shift_key_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    key_model = (v > CpsmKeyMax) ? CpsmKeyMax : v;
    key_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CpsmByteW-1:0] rand_content();
    logic [CpsmByteW-1:0] c;
    case ($urandom_range(0, 7))
      0:       c = CpsmByteW'($urandom_range(0, 255));
      1:       c = CpsmColon;
      2:       c = "s";
      3:       c = "e";
      4:       c = "t";
      7: begin
        case ($urandom_range(0, 3))
          0:       c = 8'd32;
          1:       c = 8'd33;
          2:       c = 8'd126;
          default: c = 8'd127;
        endcase
      end
      default: c = CpsmByteW'($urandom_range(33, 126));
    endcase
    return c;
  endfunction

  // mostly names that open with one or more "set", possibly cut short,
  // followed by random content; the rest plain noise
  task automatic make_random_name();
    int shape;
    int len;
    shape = $urandom_range(0, 9);
    if (shape <= 5) begin
      repeat ($urandom_range(1, 3)) add_text("set");
    end
    if (shape <= 7) begin
      len = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) name_buf.push_back(set_letter(i));
      len = $urandom_range(0, 6);
    end else begin
      len = $urandom_range(1, 8);
    end
    repeat (len) name_buf.push_back(rand_content());
    if (name_buf.size() == 0) name_buf.push_back(rand_content());
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // byte range corners and the prefix cases, reset key then saturated key
  task automatic test_directed();
    logic [CpsmByteW-1:0] corner_bytes [7] = '{8'h00, 8'h20, 8'h21, 8'h3A, 8'h7E,
                                                8'h7F, 8'hFF};
    name_buf.push_back(8'h41);      // reset key leaves it alone
    send_name();
    wait_drained();
    write_shift_key(7'd127);        // saturates to the top key
    foreach (corner_bytes[i]) name_buf.push_back(corner_bytes[i]);
    send_name();
    add_text("set");                // whole name is the prefix: rotated
    send_name();
    add_text("setx");               // prefix kept, final byte rotated
    send_name();
    add_text("setset");             // kept prefix, then prefix at name end
    send_name();
    add_text("seq");                // partial prefix broken by mismatch
    send_name();
    add_text("s");                  // single prefix letter as last byte: rotated
    send_name();
    wait_drained();
  endtask

  // random names under several keys, extremes and saturation included
  task automatic test_random_keys();
    logic [CpsmKeyW-1:0] keys [6];
    int start;
    keys = '{7'd0, 7'd93, 7'd1, 7'd127, 7'd0, 7'd0};
    keys[4] = CpsmKeyW'($urandom_range(2, 92));
    keys[5] = CpsmKeyW'($urandom_range(94, 126));
    foreach (keys[k]) begin
      write_shift_key(keys[k]);
      start = items_sent;
      while (items_sent - start < 55) begin
        make_random_name();
        send_name();
      end
      wait_drained();
    end
  endtask

  // receiver holds off long enough that the queue fills and the input stalls
  task automatic test_backpressure_hold();
    hold_req = 1'b1;
    steady   = 1'b1;
    for (int i = 0; i < 20; i++)
      send_byte(CpsmByteW'($urandom_range(33, 126)), (i % 5) == 4);
    names_sent += 4;
    wait_drained();
    hold_req = 1'b0;
    steady   = 1'b0;
  endtask

  // sender waits for a full drain after every name
  task automatic test_drain_between_names();
    repeat (4) begin
      make_random_name();
      send_name();
      wait_drained();
    end
  endtask

  // last stretch: no idling on either side
  task automatic test_full_rate();
    int start;
    quiet = 1'b1;
    write_shift_key(CpsmKeyW'($urandom_range(0, 93)));
    start = items_sent;
    while (items_sent - start < 40) begin
      make_random_name();
      send_name();
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_keys();
    test_backpressure_hold();
    test_drain_between_names();
    test_full_rate();

    if (pending_bytes.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never came out", pending_bytes.size()));

    $display("run covered %0d input bytes in %0d names over %0d key writes (saturation too),",
             items_sent, names_sent, key_writes);
    $display("with random stalls, a long output hold and a full-rate tail; %0d bytes checked",
             bytes_checked);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
